FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define TGA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// same-cycle implication
`define TGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	`TGA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define TGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	`TGA_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

FILE: src/tga_pkg.sv
// types and constants of the truecolor image stream decoder
package tga_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXELS = 2'd1,
		PH_SKIP   = 2'd2
	} tga_phase_t;

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_PIX = 2'd1,
		KIND_ERR = 2'd2
	} tga_kind_t;

	typedef enum logic [1:0] {
		ERR_FIELD     = 2'd0,
		ERR_DEPTH     = 2'd1,
		ERR_TRUNC_HDR = 2'd2,
		ERR_TRUNC_PIX = 2'd3
	} tga_err_t;

	localparam logic [4:0] POS_TYPE   = 5'd2;
	localparam logic [4:0] POS_ZERO_E = 5'd8;
	localparam logic [4:0] POS_W_LO   = 5'd12;
	localparam logic [4:0] POS_W_HI   = 5'd13;
	localparam logic [4:0] POS_H_LO   = 5'd14;
	localparam logic [4:0] POS_H_HI   = 5'd15;
	localparam logic [4:0] POS_DEPTH  = 5'd16;
	localparam logic [4:0] POS_DESC   = 5'd17;

	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [4:0] DEPTH_RGB      = 5'd3;
	localparam logic [4:0] DEPTH_RGBA     = 5'd4;
	localparam logic [2:0] CH_RGB         = 3'd3;

	localparam int MAX_RES    = 3;
	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		tga_kind_t   kind;
		logic [7:0]  pix;
		logic [15:0] w;
		logic [15:0] h;
		logic [2:0]  ch;
		tga_err_t    err;
		logic        iend;
	} tga_res_t;

	typedef struct packed {
		logic                  load;
		logic [1:0]            cnt;
		tga_res_t [MAX_RES-1:0] res;
	} tga_grp_t;

	function automatic tga_res_t tga_err_res(input tga_err_t code);
		tga_res_t r;
		r      = '0;
		r.kind = KIND_ERR;
		r.err  = code;
		return r;
	endfunction

	function automatic tga_res_t tga_pix_res(input logic [7:0] b, input logic [2:0] ch,
		input logic iend);
		tga_res_t r;
		r      = '0;
		r.kind = KIND_PIX;
		r.pix  = b;
		r.ch   = ch;
		r.iend = iend;
		return r;
	endfunction

endpackage

FILE: src/tga_dec_core.sv
// input register, decode state and per-byte result group
module tga_dec_core import tga_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  logic       grp_free,
	output tga_grp_t   grp
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       take;

	tga_phase_t  phase_q, phase_d;
	logic [4:0]  hpos_q, hpos_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        alpha_q, alpha_d;
	logic [15:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [1:0]  bip_q, bip_d;
	logic [7:0]  held0_q, held1_q;

	assign in_ready = !valid_s1 || grp_free;
	assign take     = valid_s1 && grp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

	always_comb begin
		logic [2:0]  ch;
		logic        bad;
		tga_err_t    bad_code;
		logic        empty;
		logic        completes;
		logic        last;
		logic [15:0] col_inc;
		logic [4:0]  q;

		phase_d  = phase_q;
		hpos_d   = hpos_q;
		width_d  = width_q;
		height_d = height_q;
		alpha_d  = alpha_q;
		col_d    = col_q;
		row_d    = row_q;
		bip_d    = bip_q;
		grp      = '0;
		grp.load = take;

		ch        = CH_RGB + {2'b0, alpha_q};
		bad       = 1'b0;
		bad_code  = ERR_FIELD;
		empty     = 1'b0;
		q         = byte_s1[7:3];
		completes = ({1'b0, bip_q} + 3'd1) == ch;
		last      = completes && ({1'b0, col_q} + 17'd1 == {1'b0, width_q})
			&& ({1'b0, row_q} + 17'd1 == {1'b0, height_q});
		col_inc   = col_q + 16'd1;

		case (phase_q)
			PH_HEADER: begin
				if (hpos_q == POS_TYPE) begin
					bad = (byte_s1 != TYPE_TRUECOLOR);
				end else if (hpos_q < POS_ZERO_E) begin
					bad = (byte_s1 != 8'd0);
				end else if (hpos_q == POS_W_LO) begin
					width_d = {width_q[15:8], byte_s1};
				end else if (hpos_q == POS_W_HI) begin
					width_d = {byte_s1, width_q[7:0]};
				end else if (hpos_q == POS_H_LO) begin
					height_d = {height_q[15:8], byte_s1};
				end else if (hpos_q == POS_H_HI) begin
					height_d = {byte_s1, height_q[7:0]};
				end else if (hpos_q == POS_DEPTH) begin
					if (q != DEPTH_RGB && q != DEPTH_RGBA) begin
						bad      = 1'b1;
						bad_code = ERR_DEPTH;
					end else begin
						alpha_d = (q == DEPTH_RGBA);
					end
				end

				if (bad) begin
					grp.cnt    = 2'd1;
					grp.res[0] = tga_err_res(bad_code);
					if (end_s1) begin
						phase_d = PH_HEADER;
						hpos_d  = '0;
					end else begin
						phase_d = PH_SKIP;
					end
				end else if (hpos_q >= POS_DESC) begin
					empty           = (width_q == 16'd0) || (height_q == 16'd0);
					grp.cnt         = 2'd1;
					grp.res[0].kind = KIND_HDR;
					grp.res[0].w    = width_q;
					grp.res[0].h    = height_q;
					grp.res[0].ch   = ch;
					grp.res[0].iend = empty;
					col_d           = '0;
					row_d           = '0;
					bip_d           = '0;
					if (empty) begin
						if (end_s1) begin
							phase_d = PH_HEADER;
							hpos_d  = '0;
						end else begin
							phase_d = PH_SKIP;
						end
					end else if (end_s1) begin
						grp.cnt    = 2'd2;
						grp.res[1] = tga_err_res(ERR_TRUNC_PIX);
						phase_d    = PH_HEADER;
						hpos_d     = '0;
					end else begin
						phase_d = PH_PIXELS;
					end
				end else begin
					hpos_d = hpos_q + 5'd1;
					if (end_s1) begin
						grp.cnt    = 2'd1;
						grp.res[0] = tga_err_res(ERR_TRUNC_HDR);
						phase_d    = PH_HEADER;
						hpos_d     = '0;
					end
				end
			end
			PH_PIXELS: begin
				if (end_s1 && !last) begin
					grp.cnt    = 2'd1;
					grp.res[0] = tga_err_res(ERR_TRUNC_PIX);
					phase_d    = PH_HEADER;
					hpos_d     = '0;
				end else begin
					case (bip_q)
						2'd0: bip_d = 2'd1;
						2'd1: bip_d = 2'd2;
						2'd2: begin
							grp.cnt    = 2'd3;
							grp.res[0] = tga_pix_res(byte_s1, ch, 1'b0);
							grp.res[1] = tga_pix_res(held1_q, ch, 1'b0);
							grp.res[2] = tga_pix_res(held0_q, ch, last && !alpha_q);
							bip_d      = 2'd3;
						end
						default: begin
							grp.cnt    = 2'd1;
							grp.res[0] = tga_pix_res(byte_s1, ch, last);
						end
					endcase
					if (completes) begin
						bip_d = '0;
						if (col_inc >= width_q) begin
							col_d = '0;
							row_d = row_q + 16'd1;
						end else begin
							col_d = col_inc;
						end
						if (last) begin
							if (end_s1) begin
								phase_d = PH_HEADER;
								hpos_d  = '0;
							end else begin
								phase_d = PH_SKIP;
							end
						end
					end
				end
			end
			default: begin
				if (end_s1) begin
					phase_d = PH_HEADER;
					hpos_d  = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hpos_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			alpha_q  <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			bip_q    <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			hpos_q   <= hpos_d;
			width_q  <= width_d;
			height_q <= height_d;
			alpha_q  <= alpha_d;
			col_q    <= col_d;
			row_q    <= row_d;
			bip_q    <= bip_d;
		end
	end

	function automatic logic last_hold();
		return (bip_d != bip_q) || (phase_d != PH_HEADER);
	endfunction

	// blue and green of the current pixel
	always_ff @(posedge clk) begin
		if (take && phase_q == PH_PIXELS && !(end_s1 && !last_hold())) begin
			if (bip_q == 2'd0) held0_q <= byte_s1;
			if (bip_q == 2'd1) held1_q <= byte_s1;
		end
	end

endmodule

FILE: src/tga_out_ser.sv
// result group register, drains one result beat per cycle while out_ready is high
module tga_out_ser import tga_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tga_grp_t              grp,
	output logic                  grp_free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [1:0]            out_user,
	output logic                  out_last
);

	tga_res_t   res_q [MAX_RES];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       fire;
	logic       done;
	tga_res_t   cur;

	assign cur       = res_q[idx_q];
	assign out_valid = (cnt_q != 2'd0);
	assign out_last  = (idx_q == cnt_q - 2'd1);
	assign fire      = out_valid && out_ready;
	assign done      = fire && out_last;
	assign grp_free  = !out_valid || done;
	assign out_user  = cur.kind;
	assign out_data  = {2'b0, cur.iend, cur.err, cur.ch, cur.h, cur.w, cur.pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (grp.load) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (done) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp.load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= grp.res[i];
			end
		end
	end

endmodule

FILE: src/tga_truecolor_stream_decoder_unit.sv
// top level of the truecolor image stream decoder
//
// s_axis carries one file byte per beat, tlast on the final byte of a file.
// m_axis carries results: tuser is the kind (header, pixel byte, error),
// tlast marks the last result caused by one input byte.
// the header is checked byte by byte; a good header gives one header beat
// with width, height and channel count. pixel bytes leave in R,G,B(,A)
// order: the three color beats of a pixel leave when its third byte arrives.
// after an error or a finished image, bytes are dropped up to tlast.
// throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; the third byte of a pixel gives three
// beats and holds the input, so the rate is set by the single output beat
// per cycle.
// an input register and a three-entry result group register sit between the
// two sides; a stalled receiver holds the group and stops input only once
// the input register is also full.
// reset returns the decoder to the start of a header with an empty pipeline.
module tga_truecolor_stream_decoder_unit import tga_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // file_byte
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pixel_value, image_width, image_height, channel_count, error_code, image_end
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]            m_axis_tuser,  // kind
	output logic                  m_axis_tlast
);

	tga_grp_t grp;
	logic     grp_free;

	tga_dec_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_end   (s_axis_tlast),
		.grp_free (grp_free),
		.grp      (grp)
	);

	tga_out_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.grp_free  (grp_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: src/tga_chk.sv
// port-level checker for the truecolor image stream decoder
`include "assert_macros.svh"

module tga_chk import tga_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [7:0]            s_axis_tdata,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]            m_axis_tuser,
	input logic                  m_axis_tlast
);

	`TGA_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	`TGA_ASSERT_IMP(a_err_last, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_ERR,
		m_axis_tlast)

	`TGA_ASSERT_IMP(a_pix_ch, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_PIX,
		m_axis_tdata[42:40] == 3'd3 || m_axis_tdata[42:40] == 3'd4)

	`TGA_ASSERT_IMP(a_hdr_dims, clk, arst_n,
		m_axis_tvalid && m_axis_tuser == KIND_HDR && !m_axis_tdata[45],
		m_axis_tdata[23:8] != 16'd0 && m_axis_tdata[39:24] != 16'd0)

endmodule

bind tga_truecolor_stream_decoder_unit tga_chk u_chk (.*);
